// File: rtl/clecp_pkg.sv
// Shared types, codes and constants for the character-LCD escape parser.
// No dependencies; used by every module in rtl/.
package clecp_pkg;

  // Stream byte codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CLEAR = 8'h0C;
  localparam logic [7:0] CH_HOME  = 8'h1E;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SEL0  = 8'h30;
  localparam logic [7:0] CH_SEL1  = 8'h31;
  localparam logic [7:0] CH_SEL2  = 8'h32;

  // LCD commands
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_ROW2     = 8'h40;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_DISP_CB  = 8'h0F;
  localparam logic [7:0] CMD_DISP_CUR = 8'h0E;
  localparam logic [7:0] CMD_FUNC_SET = 8'h38;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;

  // Register select codes
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  localparam int INIT_LEN        = 8;
  localparam int INIT_LONG_WAITS = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_X    = 3'd2,
    PH_Y    = 3'd3,
    PH_DISP = 3'd4
  } phase_t;

  // One queued job: either a single bus write or the whole init run
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] value;
  } job_t;

  function automatic logic [7:0] init_word(input logic [2:0] step);
    logic [7:0] w;
    case (step)
      3'd0, 3'd1, 3'd2, 3'd3: w = CMD_FUNC_SET;
      3'd4:                   w = CMD_DISP_ON;
      3'd5:                   w = CMD_CLEAR;
      3'd6:                   w = CMD_ENTRY;
      default:                w = CMD_SET_ADDR;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/clecp_front.sv
// Front end: parses stream bytes and escape sequences into queued jobs.
// Depends on clecp_pkg.
module clecp_front import clecp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,        // word accepted this cycle
  input  logic       mode,
  input  logic [7:0] stream_byte,
  output logic       push,
  output job_t       job
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] col_r, col_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      col_r   <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    col_nxt       = col_r;
    push          = 1'b0;
    job.is_init   = 1'b0;
    job.rs        = RS_CMD;
    job.value     = stream_byte;
    if (acc) begin
      if (mode) begin
        phase_nxt   = PH_IDLE;
        col_nxt     = 4'd0;
        push        = 1'b1;
        job.is_init = 1'b1;
      end else begin
        case (phase_r)
          PH_ESC: begin
            if (stream_byte == CH_EQ) begin
              phase_nxt = PH_X;
            end else if (stream_byte == CH_DOT) begin
              phase_nxt = PH_DISP;
            end else begin
              phase_nxt = PH_IDLE;
              if (stream_byte == CH_STAR) begin
                push      = 1'b1;
                job.value = CMD_CLEAR;
              end
            end
          end
          PH_X: begin
            col_nxt   = stream_byte[3:0];
            phase_nxt = PH_Y;
          end
          PH_Y: begin
            phase_nxt = PH_IDLE;
            push      = 1'b1;
            job.value = CMD_SET_ADDR | ((stream_byte != CH_NUL) ? CMD_ROW2 : 8'h00)
                        | {4'd0, col_r};
          end
          PH_DISP: begin
            phase_nxt = PH_IDLE;
            if (stream_byte == CH_SEL0) begin
              push      = 1'b1;
              job.value = CMD_DISP_ON;
            end else if (stream_byte == CH_SEL1) begin
              push      = 1'b1;
              job.value = CMD_DISP_CB;
            end else if (stream_byte == CH_SEL2) begin
              push      = 1'b1;
              job.value = CMD_DISP_CUR;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            if (stream_byte == CH_CLEAR) begin
              push      = 1'b1;
              job.value = CMD_CLEAR;
            end else if (stream_byte == CH_HOME) begin
              push      = 1'b1;
              job.value = CMD_HOME;
            end else if (stream_byte == CH_ESC) begin
              phase_nxt = PH_ESC;
            end else if (stream_byte != CH_NUL) begin
              push      = 1'b1;
              job.rs    = RS_DATA;
            end
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/clecp_queue.sv
// Small job FIFO decoupling the parser from the bus-write sequencer.
// Depends on clecp_pkg (job_t).
module clecp_queue import clecp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// File: rtl/clecp_back.sv
// Back end: expands queued jobs into bus-write words on a registered output.
// Depends on clecp_pkg (job_t, init_word).
module clecp_back import clecp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_rs,
  output logic [7:0] out_value,
  output logic       out_lw,
  output logic       out_last
);

  localparam logic [2:0] LAST_STEP = 3'(INIT_LEN - 1);

  logic       vld_r, vld_nxt;
  logic       init_act_r, init_act_nxt;
  logic [2:0] step_r, step_nxt;
  logic       rs_r, rs_nxt, lw_r, lw_nxt, last_r, last_nxt;
  logic [7:0] val_r, val_nxt;
  logic       load;

  assign load      = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_rs    = rs_r;
  assign out_value = val_r;
  assign out_lw    = lw_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      init_act_r <= 1'b0;
      step_r     <= 3'd0;
    end else begin
      vld_r      <= vld_nxt;
      init_act_r <= init_act_nxt;
      step_r     <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r   <= rs_nxt;
    val_r  <= val_nxt;
    lw_r   <= lw_nxt;
    last_r <= last_nxt;
  end

  always_comb begin
    vld_nxt      = vld_r;
    init_act_nxt = init_act_r;
    step_nxt     = step_r;
    rs_nxt       = rs_r;
    val_nxt      = val_r;
    lw_nxt       = lw_r;
    last_nxt     = last_r;
    pop          = 1'b0;
    if (load) begin
      vld_nxt = 1'b0;
      if (init_act_r) begin
        // continuing the init run
        vld_nxt  = 1'b1;
        rs_nxt   = RS_CMD;
        val_nxt  = init_word(step_r);
        lw_nxt   = (step_r < 3'(INIT_LONG_WAITS));
        last_nxt = (step_r == LAST_STEP);
        step_nxt = step_r + 3'd1;
        if (step_r == LAST_STEP) init_act_nxt = 1'b0;
      end else if (!empty) begin
        pop     = 1'b1;
        vld_nxt = 1'b1;
        if (head.is_init) begin
          rs_nxt       = RS_CMD;
          val_nxt      = init_word(3'd0);
          lw_nxt       = 1'b1;
          last_nxt     = 1'b0;
          step_nxt     = 3'd1;
          init_act_nxt = 1'b1;
        end else begin
          rs_nxt   = head.rs;
          val_nxt  = head.value;
          lw_nxt   = 1'b0;
          last_nxt = 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/char_lcd_escape_command_parser_core.sv
// Character-LCD escape parser: byte stream in, LCD bus writes out.
// An accepted word is written into the job queue, then into the output register, before it appears on out_*.
// Throughput: one input word per cycle while the job queue has room; each
// single-write job gives one bus write, an init job holds the output sequencer for its 8 writes.
// Reset (rst_n low, synchronous): parser idle, column 0, queue and output empty.
// Depends on clecp_pkg, clecp_front, clecp_queue, clecp_back.
module char_lcd_escape_command_parser_core import clecp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] bus_value, [8] long_wait, [15:9] zero
  output logic        out_tuser,  // [0] reg_select
  output logic        out_tlast   // last write caused by one input word
);

  logic       acc;
  logic       push, pop, q_empty, q_full;
  job_t       push_job, head;
  logic [7:0] bus_value;
  logic       long_wait;

  // Front side only waits for queue room; the back side stalls on its own.
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  clecp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .mode        (in_tuser),
    .stream_byte (in_tdata),
    .push        (push),
    .job         (push_job)
  );

  clecp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Output register in the back end decouples result flow from out_tready.
  clecp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rs    (out_tuser),
    .out_value (bus_value),
    .out_lw    (long_wait),
    .out_last  (out_tlast)
  );

  assign out_tdata = {7'd0, long_wait, bus_value};

endmodule

// File: bench/lcd_write_checker.sv
`timescale 1ns / 100ps
// Checker for char_lcd_escape_command_parser_core: watches both streams, predicts
// the LCD bus writes from the accepted words and compares. Depends on clecp_pkg.
module lcd_write_checker import clecp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_writes,
  output int          writes_checked,
  output int          words_taken
);

  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       long_wait;
    logic       last;
  } bus_write_t;

  bus_write_t awaited_writes[$];
  bus_write_t want;
  phase_t     parse_state;
  logic [3:0] held_col;

  function automatic bus_write_t make_write(input logic rs, input logic [7:0] value,
                                            input logic long_wait, input logic last);
    bus_write_t w;
    w.rs        = rs;
    w.value     = value;
    w.long_wait = long_wait;
    w.last      = last;
    return w;
  endfunction

  function automatic logic [7:0] power_up_cmd(input int step);
    logic [7:0] c;
    case (step)
      4:       c = CMD_DISP_ON;
      5:       c = CMD_CLEAR;
      6:       c = CMD_ENTRY;
      7:       c = CMD_SET_ADDR;
      default: c = CMD_FUNC_SET;
    endcase
    return c;
  endfunction

  // Advance the parser by one word and queue the writes it causes.
  task automatic parse_stream_word(input logic init_req, input logic [7:0] b);
    logic [7:0] row_bit;
    if (init_req) begin
      for (int k = 0; k < INIT_LEN; k++) begin
        awaited_writes.push_back(make_write(RS_CMD, power_up_cmd(k), k < INIT_LONG_WAITS,
                                            k == INIT_LEN - 1));
      end
      parse_state = PH_IDLE;
      held_col    = '0;
    end else begin
      case (parse_state)
        PH_ESC: begin
          if (b == CH_EQ) begin
            parse_state = PH_X;
          end else if (b == CH_DOT) begin
            parse_state = PH_DISP;
          end else begin
            parse_state = PH_IDLE;
            if (b == CH_STAR) awaited_writes.push_back(make_write(RS_CMD, CMD_CLEAR, 1'b0, 1'b1));
          end
        end
        PH_X: begin
          held_col    = b[3:0];
          parse_state = PH_Y;
        end
        PH_Y: begin
          parse_state = PH_IDLE;
          row_bit = (b != CH_NUL) ? CMD_ROW2 : 8'h00;
          awaited_writes.push_back(make_write(RS_CMD, CMD_SET_ADDR | row_bit | {4'h0, held_col},
                                              1'b0, 1'b1));
        end
        PH_DISP: begin
          parse_state = PH_IDLE;
          case (b)
            CH_SEL0: awaited_writes.push_back(make_write(RS_CMD, CMD_DISP_ON, 1'b0, 1'b1));
            CH_SEL1: awaited_writes.push_back(make_write(RS_CMD, CMD_DISP_CB, 1'b0, 1'b1));
            CH_SEL2: awaited_writes.push_back(make_write(RS_CMD, CMD_DISP_CUR, 1'b0, 1'b1));
            default: ;
          endcase
        end
        default: begin
          parse_state = PH_IDLE;
          case (b)
            CH_NUL:   ;
            CH_CLEAR: awaited_writes.push_back(make_write(RS_CMD, CMD_CLEAR, 1'b0, 1'b1));
            CH_HOME:  awaited_writes.push_back(make_write(RS_CMD, CMD_HOME, 1'b0, 1'b1));
            CH_ESC:   parse_state = PH_ESC;
            default:  awaited_writes.push_back(make_write(RS_DATA, b, 1'b0, 1'b1));
          endcase
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_state = PH_IDLE;
      held_col    = '0;
      awaited_writes.delete();
      fail_count     = 0;
      writes_checked = 0;
      words_taken    = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_stream_word(in_tuser, in_tdata);
        words_taken++;
      end
      if (out_tvalid && out_tready) begin
        writes_checked++;
        if (awaited_writes.size() == 0) begin
          $error("unexpected bus write: reg_select=%0d bus_value=%h", out_tuser, out_tdata[7:0]);
          fail_count++;
        end else begin
          want = awaited_writes.pop_front();
          if (out_tuser !== want.rs) begin
            $error("reg_select: expected %0d, got %0d", want.rs, out_tuser);
            fail_count++;
          end
          if (out_tdata[7:0] !== want.value) begin
            $error("bus_value: expected %h, got %h", want.value, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[8] !== want.long_wait) begin
            $error("long_wait: expected %0d, got %0d", want.long_wait, out_tdata[8]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_tlast);
            fail_count++;
          end
          if (out_tdata[15:9] !== 7'd0) begin
            $error("tdata padding: expected 0, got %h", out_tdata[15:9]);
            fail_count++;
          end
        end
      end
    end
    pending_writes = awaited_writes.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Top of the parser bench: clock, reset, byte stimulus, output back-pressure and verdict.
// Depends on clecp_pkg, char_lcd_escape_command_parser_core and lcd_write_checker.
module testbench;
  import clecp_pkg::*;

  // in_tuser codes
  localparam logic MODE_STREAM = 1'b0;
  localparam logic MODE_INIT   = 1'b1;

  localparam int IDLE_PCT      = 21;   // chance of a gap / stall per decision
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int RANDOM_WORDS  = 224;
  localparam int DRAIN_CYCLES  = 40;   // an 8-write init run, with margin

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] stream_byte
  logic        in_tuser;   // [0] mode
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] bus_value, [8] long_wait, [15:9] zero
  logic        out_tuser;  // [0] reg_select
  logic        out_tlast;

  int fail_count;
  int pending_writes;
  int writes_checked;
  int words_taken;

  int  words_sent  = 0;
  int  init_words  = 0;
  int  esc_runs    = 0;
  bit  calm        = 1'b0;  // no idling on either side while set
  bit  hold_request = 1'b0; // asks the receiver for its long hold-off
  bit  hold_done   = 1'b0;

  always #5 clk = ~clk;

  char_lcd_escape_command_parser_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  lcd_write_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending_writes (pending_writes),
    .writes_checked (writes_checked),
    .words_taken    (words_taken)
  );

  // Offer one word and return at the edge that accepts it. A random gap with
  // tvalid low may come first; tvalid is never dropped and raised in one step.
  task automatic send_word(input logic mode, input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (mode == MODE_INIT) init_words++;
  endtask

  task automatic send_text(input logic [7:0] b);
    send_word(MODE_STREAM, b);
  endtask

  task automatic send_init();
    send_word(MODE_INIT, 8'($urandom_range(0, 255)));
  endtask

  // One random piece of traffic: mostly well-formed text, control codes and
  // escape sequences with random arguments, some noise and broken escapes.
  task automatic send_random_burst();
    int         pick;
    logic [7:0] arg;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_text(8'($urandom_range(8'h20, 8'hFF)));
    end else if (pick < 35) begin
      send_text(8'($urandom_range(0, 255)));             // anything, specials included
    end else if (pick < 45) begin
      case ($urandom_range(0, 2))
        0:       send_text(CH_CLEAR);
        1:       send_text(CH_HOME);
        default: send_text(CH_NUL);
      endcase
    end else if (pick < 52) begin
      esc_runs++;
      send_text(CH_ESC);
      send_text(CH_STAR);
    end else if (pick < 72) begin
      // cursor placement: x and y random, y often zero for row one
      esc_runs++;
      send_text(CH_ESC);
      send_text(CH_EQ);
      send_text(8'($urandom_range(0, 255)));
      arg = ($urandom_range(0, 1) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
      send_text(arg);
    end else if (pick < 87) begin
      esc_runs++;
      send_text(CH_ESC);
      send_text(CH_DOT);
      if ($urandom_range(0, 4) == 0) send_text(8'($urandom_range(0, 255)));
      else send_text(8'($urandom_range(CH_SEL0, CH_SEL2)));
    end else if (pick < 94) begin
      // escape with an arbitrary second byte, usually unknown
      esc_runs++;
      send_text(CH_ESC);
      send_text(8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      send_init();
    end else begin
      // init cuts an escape short
      send_text(CH_ESC);
      if ($urandom_range(0, 1) == 0) begin
        send_text(CH_EQ);
        if ($urandom_range(0, 1) == 0) send_text(8'($urandom_range(0, 255)));
      end
      send_init();
    end
  endtask

  // Receiver: random stalls, a calm stretch, and one long hold-off while the
  // sender keeps pushing so the queue fills and in_tready drops.
  initial begin
    int n;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int random_words;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= MODE_STREAM;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every control code and escape, unknown escape
    // and selector bytes, zero as an escape argument, init in mid-escape.
    send_text(CH_NUL);
    send_text(8'hFF);
    send_text(CH_CLEAR);
    send_text(CH_HOME);
    send_text(CH_ESC);  send_text(CH_STAR);
    send_text(CH_ESC);  send_text(CH_EQ);  send_text(8'hFF);  send_text(CH_NUL);
    send_text(CH_ESC);  send_text(CH_EQ);  send_text(CH_NUL); send_text(8'hA5);
    send_text(CH_ESC);  send_text(CH_DOT); send_text(CH_SEL0);
    send_text(CH_ESC);  send_text(CH_DOT); send_text(CH_SEL1);
    send_text(CH_ESC);  send_text(CH_DOT); send_text(CH_SEL2);
    send_text(CH_ESC);  send_text(8'h55);
    send_text(CH_ESC);  send_text(CH_DOT); send_text(8'h5A);
    send_text(CH_ESC);  send_text(CH_EQ);  send_text(8'h07);
    send_word(MODE_INIT, 8'hFF);
    send_text(CH_ESC);  send_text(CH_EQ);  send_text(8'h03); send_text(8'h01);

    random_words = words_sent;
    while (words_sent - random_words < RANDOM_WORDS) begin
      hold_request = (words_sent - random_words) >= 90;
      calm = (words_sent - random_words) >= 150 && (words_sent - random_words) < 200;
      send_random_burst();
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // one edge first so the checker has counted the last accepted word
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d words sent (%0d init requests, %0d escape runs), %0d bus writes",
             words_taken, init_words, esc_runs, writes_checked);
    $display("checked, with random gaps, a calm stretch and one long output hold-off.");
    if (fail_count == 0 && pending_writes == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/clecp_pkg.sv
rtl/clecp_front.sv
rtl/clecp_queue.sv
rtl/clecp_back.sv
rtl/char_lcd_escape_command_parser_core.sv
bench/lcd_write_checker.sv
bench/testbench.sv
